/* hw/rtl/msp2rx_pkg.sv */
package msp2rx_pkg;

    // Default for the largest payload the receiver takes before it resyncs.
    localparam int MAX_PAYLOAD_DEF = 56;

    // Framing characters.
    localparam logic [7:0] SYNC_DOLLAR   = 8'h24;
    localparam logic [7:0] SYNC_X        = 8'h58;
    localparam logic [7:0] TYPE_REQ_CHAR = 8'h3C;
    localparam logic [7:0] TYPE_RSP_CHAR = 8'h3E;
    localparam logic [7:0] TYPE_ERR_CHAR = 8'h21;
    localparam logic [7:0] CRC_POLY      = 8'hD5;

    // Per-word report status.
    localparam logic [1:0] ST_LISTEN = 2'd0;
    localparam logic [1:0] ST_GOOD   = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    // Frame type codes.
    localparam logic [1:0] FT_REQUEST  = 2'd0;
    localparam logic [1:0] FT_RESPONSE = 2'd1;
    localparam logic [1:0] FT_ERROR    = 2'd2;

    // Output word layout.
    localparam int OUT_BITS    = 42;
    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic [5:0]  payload_index;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [5:0]  payload_length;
        logic [15:0] function_code;
        logic [1:0]  frame_type;
        logic        dispatch;
        logic [1:0]  status;
    } t_result;

    // One byte through the CRC-8 (poly 0xD5), MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/msp2rx_parser.sv */
module msp2rx_parser
    import msp2rx_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output t_result    o_result
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    localparam logic [2:0] PH_DOLLAR = 3'd0;
    localparam logic [2:0] PH_X      = 3'd1;
    localparam logic [2:0] PH_TYPE   = 3'd2;
    localparam logic [2:0] PH_FLAG   = 3'd3;
    localparam logic [2:0] PH_FUNC   = 3'd4;
    localparam logic [2:0] PH_LEN    = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;
    localparam logic [2:0] PH_CHECK  = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [1:0]       r_type, n_type;
    logic [15:0]      r_func, n_func;
    logic [15:0]      r_len, n_len;

    logic [7:0]       crc_next;
    logic [15:0]      len_full;
    logic [POS_W:0]   pos_inc;
    logic [15:0]      pos_ext;
    logic [1:0]       status;
    logic             dispatch;
    logic             pay_valid;
    logic [7:0]       pay_byte;
    logic [5:0]       pay_index;

    assign crc_next = crc8_update(r_crc, i_data_byte);
    assign len_full = {i_data_byte, r_len[7:0]};
    assign pos_inc  = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign pos_ext  = 16'(r_pos);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_type    = r_type;
        n_func    = r_func;
        n_len     = r_len;
        status    = ST_LISTEN;
        dispatch  = 1'b0;
        pay_valid = 1'b0;
        pay_byte  = 8'd0;
        pay_index = 6'd0;
        case (r_phase)
            PH_DOLLAR: begin
                if (i_data_byte == SYNC_DOLLAR) begin
                    n_phase = PH_X;
                end else begin
                    status = ST_ERROR;
                end
            end
            PH_X: begin
                if (i_data_byte == SYNC_X) begin
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_DOLLAR;
                    status  = ST_ERROR;
                end
            end
            PH_TYPE: begin
                if (i_data_byte == TYPE_REQ_CHAR || i_data_byte == TYPE_RSP_CHAR ||
                    i_data_byte == TYPE_ERR_CHAR) begin
                    if (i_data_byte == TYPE_REQ_CHAR) begin
                        n_type = FT_REQUEST;
                    end else if (i_data_byte == TYPE_RSP_CHAR) begin
                        n_type = FT_RESPONSE;
                    end else begin
                        n_type = FT_ERROR;
                    end
                    n_crc   = 8'd0;
                    n_phase = PH_FLAG;
                end else begin
                    n_phase = PH_DOLLAR;
                    status  = ST_ERROR;
                end
            end
            PH_FLAG: begin
                n_crc   = crc_next;
                n_pos   = '0;
                n_phase = PH_FUNC;
            end
            PH_FUNC: begin
                n_crc = crc_next;
                if (r_pos == '0) begin
                    n_func = {8'd0, i_data_byte};
                    n_pos  = POS_W'(1);
                end else begin
                    n_func  = {i_data_byte, r_func[7:0]};
                    n_pos   = '0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_crc = crc_next;
                if (r_pos == '0) begin
                    n_len = {8'd0, i_data_byte};
                    n_pos = POS_W'(1);
                end else begin
                    n_len = len_full;
                    n_pos = '0;
                    if (len_full > MAX_LEN) begin
                        n_phase = PH_DOLLAR;
                        status  = ST_ERROR;
                    end else if (len_full == 16'd0) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_crc     = crc_next;
                pay_valid = 1'b1;
                pay_byte  = i_data_byte;
                pay_index = pos_ext[5:0];
                n_pos     = pos_inc[POS_W-1:0];
                if (16'(pos_inc) >= r_len) begin
                    n_pos   = '0;
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (r_crc == i_data_byte) begin
                    status   = ST_GOOD;
                    dispatch = (r_type != FT_ERROR);
                end else begin
                    status = ST_ERROR;
                end
                n_phase = PH_DOLLAR;
            end
            default: begin
                n_phase = PH_DOLLAR;
                status  = ST_ERROR;
            end
        endcase
        if (n_phase == PH_DOLLAR) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DOLLAR;
            r_pos   <= '0;
            r_crc   <= 8'd0;
            r_type  <= FT_REQUEST;
            r_func  <= 16'd0;
            r_len   <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_func  <= n_func;
            r_len   <= n_len;
        end
    end

    always_comb begin
        o_result.status         = status;
        o_result.dispatch       = dispatch;
        o_result.frame_type     = n_type;
        o_result.function_code  = n_func;
        o_result.payload_length = n_len[5:0];
        o_result.payload_valid  = pay_valid;
        o_result.payload_byte   = pay_byte;
        o_result.payload_index  = pay_index;
    end

endmodule

/* hw/rtl/msp_v2_frame_receiver_core.sv */
// Each report is registered in the output register, or in the skid register on a stall.
// One byte per cycle while the skid register is free; the parser updates on each accepted byte.
// A full output register plus one skid register let the slave side take one more byte in a stall.
// Reset is synchronous and active low; it clears the parser state, the held frame fields
// and both output stages, and the parser then hunts for the dollar sign.
module msp_v2_frame_receiver_core
    import msp2rx_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave side: received serial bytes.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [7:0] data_byte
    // Master side: one report word per received byte.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // From bit 0 up: status[1:0], dispatch[2], frame_type[4:3], function_code[20:5],
    // payload_length[26:21], payload_valid[27], payload_byte[35:28],
    // payload_index[41:36], zero fill [47:42].
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A byte is accepted whenever the skid register is free. The parser state
    // advances on that same edge and its report is captured in the output
    // register, or in the skid register when the master side is stalled.
    logic    in_accept;
    logic    out_take;
    t_result parse_result;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take        = r_out_valid && i_m_axis_tready;

    msp2rx_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_s_axis_tdata),
        .o_result    (parse_result)
    );

    // Output register and skid register. When the output register is free
    // (empty or being taken), a parked skid word moves up first; otherwise a
    // fresh report goes straight in. A stalled output sends a fresh report
    // to the skid register, which closes the slave side until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= parse_result;
            end
        end else if (in_accept) begin
            r_skid <= parse_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), r_out.payload_index,
                              r_out.payload_byte, r_out.payload_valid,
                              r_out.payload_length, r_out.function_code,
                              r_out.frame_type, r_out.dispatch, r_out.status};

`ifndef ASSERT_OFF
    // A word can only be parked in the skid register behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");

    // Dispatch is only raised on a frame that closed with a good CRC.
    a_dispatch_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.dispatch) |-> (r_out.status == ST_GOOD &&
                                             r_out.frame_type != FT_ERROR))
        else $error("dispatch raised without a good non-error frame");

    // A payload byte is never also the byte that closes or breaks a frame.
    a_payload_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_valid) |-> (r_out.status == ST_LISTEN))
        else $error("payload byte reported with a frame status");

    // After an accepted byte the output register always holds a word, its report or an older one.
    a_accept_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted byte produced no report");
`endif

endmodule
